// ===== rtl/iqs_pkg.sv =====
`timescale 1ns / 1ps
package iqs_pkg;

  localparam int IDX_W  = 31;
  localparam int KEY_W  = 64;
  localparam int ITEM_W = IDX_W + KEY_W;

  // Configuration register indexes.
  localparam logic REG_KEY_IS_DOUBLE = 1'b0;
  localparam logic REG_ASCENDING     = 1'b1;

  // Magnitude of an infinity; anything above it is a NaN.
  localparam logic [62:0] EXP_ALL = 63'h7FF0_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_CHK,
    ST_PIVOT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SWAP_J,
    ST_FIN_RD,
    ST_FIN_WR_HI,
    ST_FIN_WR_P,
    ST_PUSH_HI,
    ST_PUSH_LO,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sort_start;
    logic pop_rd;
    logic pop_chk;
    logic pivot;
    logic scan_rd;
    logic scan_wp;
    logic scan_skip;
    logic swap_j;
    logic fin_rd;
    logic fin_wr_hi;
    logic fin_wr_p;
    logic push_hi;
    logic push_lo;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sort_now;
    logic multi;
    logic range_ok;
    logic scan_done;
    logic ahead;
    logic push_lo_ok;
    logic stack_empty;
    logic emit_last;
  } status_t;

  function automatic logic [63:0] dbl_order(input logic [63:0] v);
    dbl_order = v[63] ? ~v : {1'b1, v[62:0]};
  endfunction

  // Double compare: NaN compares false, the two zeros compare equal.
  function automatic logic dbl_less(input logic [63:0] a, input logic [63:0] b);
    logic nan;
    logic zeros;
    nan   = (a[62:0] > EXP_ALL) || (b[62:0] > EXP_ALL);
    zeros = (a[62:0] == '0) && (b[62:0] == '0);
    dbl_less = !nan && !zeros && (dbl_order(a) < dbl_order(b));
  endfunction

  function automatic logic key_less(input logic [63:0] a, input logic [63:0] b,
                                    input logic dbl);
    key_less = dbl ? dbl_less(a, b) : ($signed(a[31:0]) < $signed(b[31:0]));
  endfunction

  function automatic logic goes_before(input logic [63:0] a, input logic [63:0] piv,
                                       input logic dbl, input logic asc);
    goes_before = asc ? key_less(a, piv, dbl) : key_less(piv, a, dbl);
  endfunction

endpackage

// ===== rtl/iqs_ctrl.sv =====
`timescale 1ns / 1ps
module iqs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  iqs_pkg::status_t sts,
  output iqs_pkg::cmd_t    cmd,
  output logic            busy
);
  import iqs_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && sts.sort_now) begin
          state_next = sts.multi ? ST_POP_RD : ST_EMIT;
        end
      end
      ST_POP_RD:    state_next = ST_POP_CHK;
      ST_POP_CHK: begin
        if (sts.range_ok) begin
          state_next = ST_PIVOT;
        end else begin
          state_next = sts.stack_empty ? ST_EMIT : ST_POP_RD;
        end
      end
      ST_PIVOT:     state_next = ST_SCAN_RD;
      ST_SCAN_RD:   state_next = sts.scan_done ? ST_FIN_RD : ST_SCAN_CMP;
      ST_SCAN_CMP:  state_next = sts.ahead ? ST_SWAP_J : ST_SCAN_RD;
      ST_SWAP_J:    state_next = ST_SCAN_RD;
      ST_FIN_RD:    state_next = ST_FIN_WR_HI;
      ST_FIN_WR_HI: state_next = ST_FIN_WR_P;
      ST_FIN_WR_P:  state_next = ST_PUSH_HI;
      ST_PUSH_HI:   state_next = ST_PUSH_LO;
      ST_PUSH_LO: begin
        state_next = (sts.stack_empty && !sts.push_lo_ok) ? ST_EMIT : ST_POP_RD;
      end
      ST_EMIT:      state_next = sts.emit_last ? ST_IDLE : ST_EMIT;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && start;
    cmd.sort_start = (state == ST_IDLE) && start && sts.sort_now;
    cmd.pop_rd     = (state == ST_POP_RD);
    cmd.pop_chk    = (state == ST_POP_CHK);
    cmd.pivot      = (state == ST_PIVOT);
    cmd.scan_rd    = (state == ST_SCAN_RD) && !sts.scan_done;
    cmd.scan_wp    = (state == ST_SCAN_CMP) && sts.ahead;
    cmd.scan_skip  = (state == ST_SCAN_CMP) && !sts.ahead;
    cmd.swap_j     = (state == ST_SWAP_J);
    cmd.fin_rd     = (state == ST_FIN_RD);
    cmd.fin_wr_hi  = (state == ST_FIN_WR_HI);
    cmd.fin_wr_p   = (state == ST_FIN_WR_P);
    cmd.push_hi    = (state == ST_PUSH_HI);
    cmd.push_lo    = (state == ST_PUSH_LO);
    cmd.emit       = (state == ST_EMIT);
    busy           = (state != ST_IDLE);
  end

  // Loads only happen while idle, a compare always follows a store read, and
  // the final result beat returns the controller to idle.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy) else $error("load while busy");
  a_cmp_follows_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN_CMP |-> $past(state) == ST_SCAN_RD) else $error("compare without read");
  a_emit_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && sts.emit_last) |=> state == ST_IDLE) else $error("emit overrun");

endmodule

// ===== rtl/iqs_datapath.sv =====
`timescale 1ns / 1ps
module iqs_datapath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  iqs_pkg::cmd_t        cmd,
  output iqs_pkg::status_t     sts,
  input  logic [30:0]          item_index,
  input  logic signed [63:0]   item_key,
  input  logic                 item_last,
  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic                 wr_data,
  output logic                 strobe,
  output logic [30:0]          sorted_index,
  output logic                 out_last
);
  import iqs_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  // Item store: index and key side by side, two registered read ports.
  logic [ITEM_W-1:0] mem [MAX_ITEMS];
  logic [ITEM_W-1:0] ra_q, rb_q;
  logic [AW-1:0]     ra, rb, wa;
  logic              re_a, re_b, we;
  logic [ITEM_W-1:0] wd;

  // Range stack: {left, right} per entry.
  logic [2*AW-1:0] stk [MAX_ITEMS];
  logic [2*AW-1:0] st_q;
  logic [2*AW-1:0] st_wd;
  logic            st_we;

  logic [CW-1:0]     count, n, depth, depth_m1;
  logic [AW-1:0]     lo, hi, p, j, k;
  logic [AW-1:0]     st_lo, st_hi;
  logic [ITEM_W-1:0] pivot;
  logic              key_is_double, ascending;
  logic              emit_d, last_d;
  logic              space;

  assign st_lo    = st_q[2*AW-1:AW];
  assign st_hi    = st_q[AW-1:0];
  assign depth_m1 = depth - CW'(1);
  assign space    = depth < MAX_C;

  // Status toward the controller.
  always_comb begin
    sts.sort_now    = item_last || (count == MAX_C - CW'(1));
    sts.multi       = (count != '0);
    sts.range_ok    = (st_lo < st_hi) && ({{(CW-AW){1'b0}}, st_hi} < n);
    sts.scan_done   = (j == hi);
    sts.ahead       = goes_before(ra_q[KEY_W-1:0], pivot[KEY_W-1:0],
                                  key_is_double, ascending);
    sts.push_lo_ok  = {1'b0, p} > ({1'b0, lo} + (AW+1)'(1));
    sts.stack_empty = (depth == '0);
    sts.emit_last   = ({{(CW-AW){1'b0}}, k} == n - CW'(1));
  end

  // Item store address and data selection.
  always_comb begin
    re_a = 1'b0;
    re_b = 1'b0;
    ra   = j;
    rb   = p;
    we   = 1'b0;
    wa   = p;
    wd   = ra_q;
    priority if (cmd.load) begin
      we = 1'b1;
      wa = count[AW-1:0];
      wd = {item_index, item_key};
    end else if (cmd.pop_chk) begin
      re_a = 1'b1;
      ra   = st_hi;
    end else if (cmd.scan_rd) begin
      re_a = 1'b1;
      re_b = 1'b1;
    end else if (cmd.scan_wp) begin
      we = 1'b1;
    end else if (cmd.swap_j) begin
      we = 1'b1;
      wa = j;
      wd = rb_q;
    end else if (cmd.fin_rd) begin
      re_b = 1'b1;
    end else if (cmd.fin_wr_hi) begin
      we = 1'b1;
      wa = hi;
      wd = rb_q;
    end else if (cmd.fin_wr_p) begin
      we = 1'b1;
      wd = pivot;
    end else if (cmd.emit) begin
      re_a = 1'b1;
      ra   = k;
    end else begin
      we = 1'b0;
    end
  end

  // Item store.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      ra_q <= mem[ra];
    end
    if (re_b) begin
      rb_q <= mem[rb];
    end
  end

  // Range stack writes: the full range at sort start, then split ranges.
  always_comb begin
    st_we = 1'b0;
    st_wd = {lo, p - AW'(1)};
    priority if (cmd.sort_start) begin
      st_we = sts.multi;
      st_wd = {{AW{1'b0}}, count[AW-1:0]};
    end else if (cmd.push_hi) begin
      st_we = space && ({1'b0, p} + (AW+1)'(1) < {1'b0, hi});
      st_wd = {p + AW'(1), hi};
    end else if (cmd.push_lo) begin
      st_we = space && sts.push_lo_ok;
    end else begin
      st_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stk[depth[AW-1:0]] <= st_wd;
    end
    if (cmd.pop_rd) begin
      st_q <= stk[depth_m1[AW-1:0]];
    end
  end

  // Control counters and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      depth         <= '0;
      key_is_double <= 1'b0;
      ascending     <= 1'b1;
      emit_d        <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_KEY_IS_DOUBLE: key_is_double <= wr_data;
          REG_ASCENDING:     ascending     <= wr_data;
          default:           ascending     <= ascending;
        endcase
      end
      if (cmd.load) begin
        count <= sts.sort_now ? '0 : count + CW'(1);
      end
      if (cmd.sort_start) begin
        depth <= sts.multi ? CW'(1) : '0;
      end else if (cmd.pop_rd) begin
        depth <= depth_m1;
      end else if (st_we) begin
        depth <= depth + CW'(1);
      end
      emit_d <= cmd.emit;
      strobe <= emit_d;
    end
  end

  // Partition pointers and pivot.
  always_ff @(posedge clk) begin
    if (cmd.sort_start) begin
      n <= count + CW'(1);
      k <= '0;
    end
    if (cmd.pop_chk) begin
      lo <= st_lo;
      hi <= st_hi;
      p  <= st_lo;
      j  <= st_lo;
    end
    if (cmd.pivot) begin
      pivot <= ra_q;
    end
    if (cmd.scan_skip) begin
      j <= j + AW'(1);
    end
    if (cmd.swap_j) begin
      j <= j + AW'(1);
      p <= p + AW'(1);
    end
    if (cmd.emit) begin
      k <= k + AW'(1);
    end
    last_d <= sts.emit_last;
  end

  // Result register: the read of the store lines up with the delayed strobe.
  always_ff @(posedge clk) begin
    sorted_index <= ra_q[ITEM_W-1:KEY_W];
    out_last     <= last_d;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= MAX_C) else $error("range stack overflow");
  a_p_behind_j: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> p <= j) else $error("partition pointer ahead of scan");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_rd |-> depth != '0) else $error("pop of empty stack");

endmodule

// ===== rtl/index_quicksort_unit.sv =====
`timescale 1ns / 1ps
// Index quicksort unit. Items (index, key) are loaded one beat per cycle while
// busy is low; the item marked last, or the one that fills the store to
// MAX_ITEMS entries, starts a Lomuto quicksort of the stored list (pivot is the
// last element of each range, ranges kept on a stack). The block then raises
// busy and, when sorting is done, shows the indices in key order, one beat per
// cycle on strobe, with out_last on the final one. The receiver cannot stall:
// every strobe beat must be taken in the cycle it appears. Each range is popped
// from the stack, its pivot read, its elements read and compared one by one,
// with a swap for each that moves ahead of the pivot, then the pivot is written
// into place and the split ranges that still need sorting are pushed. Each swap
// is split into steps, since the item store has a single write port through
// which each swap passes one entry at a time. Configuration written while
// busy is low applies to the next sort.
module index_quicksort_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [30:0]        item_index,
  input  logic signed [63:0] item_key,
  input  logic               item_last,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic               wr_data,
  output logic               strobe,
  output logic [30:0]        sorted_index,
  output logic               out_last
);
  import iqs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  iqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  iqs_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item_index   (item_index),
    .item_key     (item_key),
    .item_last    (item_last),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .strobe       (strobe),
    .sorted_index (sorted_index),
    .out_last     (out_last)
  );

endmodule
